FILE: sv/ias_pkg.sv
// Shared types for the integer array sorter: element data and cell link records.
package ias_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  // What one cell shows to its neighbours
  typedef struct packed {
    logic  valid;
    data_t value;
    logic  greater;   // stored value is above the element being inserted
  } cell_link_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: sv/ias_chan_if.sv
// Valid/ready channel interfaces for the sorter's input and result streams.
interface ias_in_if import ias_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ias_out_if import ias_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  final_res;
  logic  overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

FILE: sv/ias_cell.sv
// One cell of the insertion chain: holds one sorted element, shifts up on insert, down on drain.
module ias_cell import ias_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  data_t      din,
  input  cell_link_t prev,
  input  cell_link_t next,
  output cell_link_t self
);

  logic  valid_r, valid_nxt;
  data_t value_r, value_nxt;
  logic  greater;

  // strict compare keeps equal values in arrival order
  assign greater = valid_r && (din < value_r);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      // drain: take the element above
      valid_nxt = next.valid;
      value_nxt = next.value;
    end else if (ctrl.insert) begin
      if (greater || (!valid_r && prev.valid)) begin
        valid_nxt = 1'b1;
        value_nxt = prev.greater ? prev.value : din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign self = '{valid: valid_r, value: value_r, greater: greater};

endmodule

FILE: sv/integer_array_sorter_core.sv
// Timing: a set loads at one element per cycle while no run drains; its first result is offered
// the cycle after the closing request is taken, then one result per cycle while the sink takes them.
// Flow: a set loads in the insertion chain and drains through its bottom cell; no input is
// taken while a run drains.
// Reset: synchronous active-low rst_n empties the chain and clears the overflow flag.
// Top level of the integer array sorter: control around a chain of insertion cells.
module integer_array_sorter_core import ias_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk,
  input logic      rst_n,
  ias_in_if.sink   in_chan,
  ias_out_if.source out_chan
);

  cell_link_t links [DEPTH];
  cell_ctrl_t ctrl;

  logic draining_r, draining_nxt;
  logic dropped_r, dropped_nxt;
  logic full;
  logic in_acc;
  logic out_acc;
  logic final_res;

  assign full      = links[DEPTH-1].valid;
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_acc   = out_chan.valid && out_chan.ready;
  assign final_res = !links[1].valid;

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_link_t prev_l;
      cell_link_t next_l;
      if (gi == 0) begin : g_bottom
        assign prev_l = '{valid: 1'b1, value: '0, greater: 1'b0};
      end else begin : g_mid_lo
        assign prev_l = links[gi-1];
      end
      if (gi == DEPTH-1) begin : g_top
        assign next_l = '{valid: 1'b0, value: '0, greater: 1'b0};
      end else begin : g_mid_hi
        assign next_l = links[gi+1];
      end
      ias_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ctrl),
        .din  (in_chan.value),
        .prev (prev_l),
        .next (next_l),
        .self (links[gi])
      );
    end
  endgenerate

  always_comb begin
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    if (out_acc && final_res) begin
      // run complete: chain is empty again
      draining_nxt = 1'b0;
      dropped_nxt  = 1'b0;
    end else if (in_acc) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_chan.last) begin
        draining_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      dropped_r  <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

  assign in_chan.ready         = !draining_r;
  assign out_chan.valid        = draining_r && links[0].valid;
  assign out_chan.sorted_value = links[0].value;
  assign out_chan.final_res    = final_res;
  assign out_chan.overflow     = dropped_r;

`ifndef SYNTHESIS
  a_drop_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && full |=> dropped_r)
    else $error("dropped request not flagged");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && final_res |=> !draining_r && !links[0].valid)
    else $error("chain not empty after final result");

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> links[0].valid)
    else $error("draining with empty bottom cell");

  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    links[1].valid |-> links[0].valid)
    else $error("gap at bottom of chain");
`endif

endmodule

FILE: tb/sv/integer_array_sorter_core_tb.sv
// Self-checking testbench for the integer array sorter: random sets, stalls and overflow.
`timescale 1ns / 100ps

module integer_array_sorter_core_tb;
  import ias_pkg::*;

  localparam int unsigned Depth         = 64;
  localparam int          RandomItems   = 64;
  localparam int          CalmTail      = 40;    // no idling once this few requests remain
  localparam int          HoldCycles    = 400;
  localparam int          WatchdogLimit = 4000;
  localparam int          TailCycles    = 20;
  localparam int          MaxReports    = 10;
  localparam data_t       MinVal        = 32'sh8000_0000;
  localparam data_t       MaxVal        = 32'sh7fff_ffff;

  typedef struct packed {
    data_t value;
    logic  last;
  } element_req_t;

  typedef struct packed {
    data_t sorted_value;
    logic  final_res;
    logic  overflow;
  } sorted_res_t;

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  data_t in_value  = '0;
  logic  in_last   = 1'b0;
  logic  out_ready = 1'b0;

  ias_in_if  in_if ();
  ias_out_if out_if ();

  assign in_if.valid  = in_valid;
  assign in_if.value  = in_value;
  assign in_if.last   = in_last;
  assign out_if.ready = out_ready;

  integer_array_sorter_core #(.DEPTH(Depth)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  element_req_t pending_reqs[$];
  element_req_t next_req;
  data_t        held_elems[$];     // current set, kept in ascending order
  logic         set_dropped = 1'b0;
  sorted_res_t  sorted_exp[$];
  sorted_res_t  exp_res;

  int in_taken      = 0;
  int sets_closed   = 0;
  int overflow_runs = 0;
  int res_checked   = 0;
  int mismatches    = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  int hold_at       = -1;
  int quiet_cycles  = 0;
  logic hold_done   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void push_req(data_t v, logic l);
    element_req_t r;
    r.value = v;
    r.last  = l;
    pending_reqs.push_back(r);
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 4))
      0: return data_t'($urandom_range(0, 16)) - data_t'(8);
      1: begin
        case ($urandom_range(0, 3))
          0:       return MinVal;
          1:       return MaxVal;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // Insert behind any equals; drop when full; on close, emit the whole set.
  function automatic void load_element(data_t v, logic closes);
    int          pos;
    int          k;
    sorted_res_t r;
    if (held_elems.size() < Depth) begin
      pos = held_elems.size();
      while (pos > 0 && held_elems[pos-1] > v) pos--;
      held_elems.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (closes) begin
      for (k = 0; k < held_elems.size(); k++) begin
        r.sorted_value = held_elems[k];
        r.final_res    = (k == held_elems.size() - 1);
        r.overflow     = set_dropped;
        sorted_exp.push_back(r);
      end
      sets_closed++;
      if (set_dropped) overflow_runs++;
      held_elems.delete();
      set_dropped = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH: %s", msg);
  endfunction

  // Driver: present the next request once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_if.ready) begin
      if (in_valid) begin
        load_element(in_value, in_last);
        in_taken <= in_taken + 1;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > CalmTail && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        in_value <= next_req.value;
        in_last  <= next_req.last;
        in_valid <= 1'b1;
      end
    end
  end

  // Long hold-off on the result side, starting with the overflowing set.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && in_taken == hold_at) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (pending_reqs.size() > CalmTail && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare every taken result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_ready) begin
      if (sorted_exp.size() == 0) begin
        note_mismatch($sformatf("unexpected result value=%0d final=%0b overflow=%0b",
                                out_if.sorted_value, out_if.final_res, out_if.overflow));
      end else begin
        exp_res = sorted_exp.pop_front();
        res_checked++;
        if (out_if.sorted_value !== exp_res.sorted_value ||
            out_if.final_res !== exp_res.final_res ||
            out_if.overflow !== exp_res.overflow) begin
          note_mismatch($sformatf(
            "result %0d: expected value=%0d final=%0b overflow=%0b, got %0d/%0b/%0b",
            res_checked, exp_res.sorted_value, exp_res.final_res, exp_res.overflow,
            out_if.sorted_value, out_if.final_res, out_if.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_if.ready) || (out_if.valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("Watchdog: no request moved for %0d cycles", WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int rand_items;
    int n;
    int k;

    // Single-element sets at both extremes.
    push_req(MinVal, 1'b1);
    push_req(MaxVal, 1'b1);
    // Extremes mixed with duplicates.
    push_req('0, 1'b0);
    push_req('1, 1'b0);
    push_req(MaxVal, 1'b0);
    push_req(MinVal, 1'b0);
    push_req(data_t'(1), 1'b0);
    push_req(MinVal, 1'b0);
    push_req(MaxVal, 1'b1);
    // All equal.
    push_req(data_t'(5), 1'b0);
    push_req(data_t'(5), 1'b0);
    push_req(data_t'(5), 1'b1);
    // Descending to zero, then ascending across zero.
    push_req(data_t'(3), 1'b0);
    push_req(data_t'(2), 1'b0);
    push_req(data_t'(1), 1'b0);
    push_req('0, 1'b1);
    push_req(data_t'(-2), 1'b0);
    push_req('1, 1'b0);
    push_req('0, 1'b0);
    push_req(data_t'(1), 1'b1);

    // A set that fills the store and overflows, including its closing element.
    hold_at = pending_reqs.size();
    for (k = 0; k < Depth + 2; k++) push_req(pick_value(), k == Depth + 1);

    rand_items = 0;
    while (rand_items < RandomItems) begin
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) push_req(pick_value(), k == n - 1);
      rand_items += n;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || sorted_exp.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sorted %0d sets (%0d with dropped elements) from %0d requests, %0d results checked.",
             sets_closed, overflow_runs, in_taken, res_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && sorted_exp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
